// ===== rtl/cqsr_pkg.sv =====
// ----------------------------------------------------------------------------
// cqsr_pkg
// Shared constants and types of the cell quality sample reservoir.
// ----------------------------------------------------------------------------
package cqsr_pkg;
    localparam int CAPACITY = 64;
    localparam int SLOTS    = CAPACITY + 1;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int CELL_W   = 17;
    localparam int ENT_W    = 2 * CELL_W + 16 + 1 + 32;

    localparam logic [1:0] REG_CELL_SIZE = 2'd0;
    localparam logic [1:0] REG_TTL       = 2'd1;
    localparam logic [1:0] REG_MAX_CELLS = 2'd2;
    localparam logic [1:0] REG_QMIN      = 2'd3;

    localparam logic [1:0] KIND_HEAD  = 2'd1;
    localparam logic [1:0] KIND_CHEST = 2'd2;

    typedef struct packed {
        logic [1:0]         sample_kind;
        logic signed [15:0] position_x_mm;
        logic signed [15:0] position_z_mm;
        logic [15:0]        quality;
        logic [31:0]        time_ms;
    } t_in;

    typedef struct packed {
        logic       admitted;
        logic [6:0] occupied_count;
        logic [6:0] heads_held;
        logic [6:0] chests_held;
    } t_out;

    typedef struct packed {
        logic signed [CELL_W-1:0] cx;
        logic signed [CELL_W-1:0] cz;
        logic [15:0]              q;
        logic                     is_head;
        logic [31:0]              t;
    } t_entry;
endpackage

// ===== rtl/cqsr_if.sv =====
// ----------------------------------------------------------------------------
// cqsr_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface cqsr_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cell_quality_sample_reservoir.sv =====
// ----------------------------------------------------------------------------
// cell_quality_sample_reservoir
// Grid-cell keyed sample table with admission, expiry and eviction.
// Steps per sample: two divisions, a lookup pass, an update step, an expiry pass
//   and one count pass per eviction plus one, where each count pass finds the
//   worst entry and either evicts it or produces the result.
// A new sample is not taken until the result has been accepted; input waits meanwhile.
// Reset clears the valid bits at once; configuration returns to its defaults.
// ----------------------------------------------------------------------------
module cell_quality_sample_reservoir (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cqsr_if.sink             i_in,
    cqsr_if.source           o_out,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data
);
    import cqsr_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_DIVX  = 8'b00000010,
        S_DIVZ  = 8'b00000100,
        S_LOOK  = 8'b00001000,
        S_UPD   = 8'b00010000,
        S_EXP   = 8'b00100000,
        S_EVICT = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state r_state;
    logic [13:0] r_cell;
    logic [31:0] r_ttl;
    logic [6:0]  r_maxc;
    logic [15:0] r_qmin;
    t_in         r_in;
    logic [SLOTS-1:0] r_valid;
    logic signed [CELL_W-1:0] r_cx, r_cz;
    logic [SLOT_W:0] r_idx;        // pass counter, one ahead of RAM data
    logic [SLOT_W-1:0] r_hit, r_free, r_worst;
    logic r_hit_ok, r_free_ok, r_worst_ok, r_adm, r_gate;
    logic [15:0] r_hitq, r_worstq;
    logic [CNT_W-1:0] r_cnt, r_heads;
    logic [6:0] r_cap;
    t_out r_res;

    logic div_start, div_done;
    logic signed [CELL_W-1:0] div_q;
    logic signed [15:0] div_a;
    logic [13:0] eff_cell;

    logic ram_we;
    logic [SLOT_W-1:0] ram_wa, ram_ra, cur;
    t_entry ram_wd, ram_rd;
    logic [19:0] lhs, rhs;
    logic [31:0] age;
    logic admissible;
    logic cur_live;
    logic take_worst;
    logic [SLOT_W-1:0] n_worst;
    logic n_worst_ok;
    logic [CNT_W-1:0] n_heads;

    assign eff_cell = (r_cell < 14'd2) ? 14'd300 : r_cell;
    assign div_a = (r_state == S_DIVX) ? r_in.position_x_mm : r_in.position_z_mm;

    cqsr_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_a(div_a),
        .i_c(eff_cell), .o_done(div_done), .o_q(div_q)
    );

    cqsr_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(ram_wd),
        .i_raddr(ram_ra), .o_rdata(ram_rd)
    );

    assign ram_ra = r_idx[SLOT_W-1:0];
    assign cur = SLOT_W'(r_idx - 1'b1);
    assign cur_live = (r_idx != '0) && r_valid[cur];
    assign admissible = (r_in.sample_kind == KIND_HEAD || r_in.sample_kind == KIND_CHEST)
                        && r_in.quality >= r_qmin;
    assign lhs = 20'(r_in.quality) * 20'd10;
    assign rhs = 20'(r_hitq) * 20'd9;
    assign age = r_in.time_ms - ram_rd.t;

    // Worst entry and head count including the slot on the RAM output now.
    assign take_worst = cur_live && (!r_worst_ok || ram_rd.q < r_worstq);
    assign n_worst = take_worst ? cur : r_worst;
    assign n_worst_ok = r_worst_ok || cur_live;
    assign n_heads = (cur_live && ram_rd.is_head) ? r_heads + 1'b1 : r_heads;

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.data = r_res;

    always_comb begin
        ram_we = 1'b0;
        ram_wa = r_hit_ok ? r_hit : r_free;
        ram_wd.cx = r_cx;
        ram_wd.cz = r_cz;
        ram_wd.q = r_in.quality;
        ram_wd.is_head = (r_in.sample_kind == KIND_HEAD);
        ram_wd.t = r_in.time_ms;
        if (r_state == S_UPD && r_gate) begin
            if (r_hit_ok) ram_we = (lhs >= rhs);
            else          ram_we = r_free_ok;
        end
        div_start = (r_state == S_DIVX && r_gate) || (r_state == S_DIVZ && r_gate);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_cell  <= 14'd300;
            r_ttl   <= 32'd10000;
            r_maxc  <= 7'd64;
            r_qmin  <= 16'd0;
            r_gate  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CELL_SIZE: r_cell <= i_cfg_data[13:0];
                    REG_TTL:       r_ttl  <= i_cfg_data;
                    REG_MAX_CELLS: r_maxc <= i_cfg_data[6:0];
                    REG_QMIN:      r_qmin <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_in <= i_in.data;
                        r_gate <= 1'b1;
                        r_adm <= 1'b0;
                        if (r_maxc == 7'd0) r_cap <= 7'd1;
                        else if (r_maxc > 7'(CAPACITY)) r_cap <= 7'(CAPACITY);
                        else r_cap <= r_maxc;
                        r_state <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    r_gate <= div_done;
                    if (div_done) begin
                        r_cx <= div_q;
                        r_state <= S_DIVZ;
                    end
                end
                S_DIVZ: begin
                    r_gate <= 1'b0;
                    if (div_done) begin
                        r_cz <= div_q;
                        r_idx <= '0;
                        r_hit_ok <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    // Data for slot cur is on the RAM output this cycle.
                    if (r_idx != '0) begin
                        if (r_valid[cur]) begin
                            if (!r_hit_ok && ram_rd.cx == r_cx && ram_rd.cz == r_cz) begin
                                r_hit_ok <= 1'b1;
                                r_hit <= cur;
                                r_hitq <= ram_rd.q;
                            end
                        end else if (!r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free <= cur;
                        end
                    end
                    if (r_idx == (SLOT_W+1)'(SLOTS)) begin
                        r_gate <= admissible;
                        r_state <= S_UPD;
                    end else r_idx <= r_idx + 1'b1;
                end
                S_UPD: begin
                    if (ram_we) begin
                        r_adm <= 1'b1;
                        if (!r_hit_ok) r_valid[r_free] <= 1'b1;
                    end
                    r_idx <= '0;
                    r_cnt <= '0;
                    r_state <= S_EXP;
                end
                S_EXP: begin
                    if (cur_live) begin
                        if (age > r_ttl) r_valid[cur] <= 1'b0;
                        else r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_idx == (SLOT_W+1)'(SLOTS)) begin
                        r_idx <= '0;
                        r_worst_ok <= 1'b0;
                        r_heads <= '0;
                        r_state <= S_EVICT;
                    end else r_idx <= r_idx + 1'b1;
                end
                S_EVICT: begin
                    // One pass finds the worst entry and counts heads.
                    if (r_idx == (SLOT_W+1)'(SLOTS)) begin
                        r_idx <= '0;
                        r_worst_ok <= 1'b0;
                        r_heads <= '0;
                        if (r_cnt > CNT_W'(r_cap) && n_worst_ok) begin
                            r_valid[n_worst] <= 1'b0;
                            r_cnt <= r_cnt - 1'b1;
                        end else begin
                            r_res.admitted <= r_adm;
                            r_res.occupied_count <= 7'(r_cnt);
                            r_res.heads_held <= 7'(n_heads);
                            r_res.chests_held <= 7'(r_cnt - n_heads);
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_heads <= n_heads;
                        r_worst_ok <= n_worst_ok;
                        if (take_worst) begin
                            r_worst <= cur;
                            r_worstq <= ram_rd.q;
                        end
                    end
                end
                S_OUT: begin
                    if (o_out.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/cqsr_ram.sv =====
// ----------------------------------------------------------------------------
// cqsr_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cqsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/cqsr_div.sv =====
// ----------------------------------------------------------------------------
// cqsr_div
// Restoring divider, one quotient bit a cycle, giving floor(a / c) for
// a signed 16-bit dividend and a positive 14-bit divisor.
// ----------------------------------------------------------------------------
module cqsr_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [15:0]             i_a,
    input  logic [13:0]                    i_c,
    output logic                           o_done,
    output logic signed [cqsr_pkg::CELL_W-1:0] o_q
);
    import cqsr_pkg::*;
    logic [15:0] r_mag, n_mag;
    logic [14:0] r_rem, n_rem;
    logic [13:0] r_c;
    logic        r_neg;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [14:0] w_trial;
    logic [16:0] w_qadj;

    always_comb begin
        w_trial = {r_rem[13:0], r_mag[15]};
        n_mag = {r_mag[14:0], 1'b0};
        n_rem = w_trial;
        if (w_trial >= {1'b0, r_c}) begin
            n_rem = w_trial - {1'b0, r_c};
            n_mag[0] = 1'b1;
        end
        // Negative dividends round toward minus infinity.
        if (r_neg) w_qadj = (r_rem != '0) ? -({1'b0, r_mag} + 17'd1) : -{1'b0, r_mag};
        else       w_qadj = {1'b0, r_mag};
    end
    assign o_q = signed'(w_qadj);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
                r_rem  <= '0;
                r_c    <= i_c;
                r_neg  <= i_a[15];
                r_mag  <= i_a[15] ? 16'(-i_a) : 16'(i_a);
            end else if (r_busy) begin
                r_mag <= n_mag;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
